// ----- hw/rtl/gyro_encoder_odometry_assert.svh -----
// Assertion macros for the odometry block, empty when synthesized.
`ifndef GYRO_ENCODER_ODOMETRY_ASSERT_SVH
`define GYRO_ENCODER_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
`define GEO_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odometry check failed");
`define GEO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry check failed");
`else
`define GEO_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GEO_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/geo_pkg.sv -----
// Shared types, constants and the arctangent table of the odometry block.
package geo_pkg;

   localparam int DefaultIterations = 16;
   localparam int CntW = 6;
   localparam int DivSteps = 49;

   localparam logic [1:0] CsrStartX = 2'd0;
   localparam logic [1:0] CsrStartY = 2'd1;
   localparam logic [1:0] CsrStartAngle = 2'd2;

   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic [34:0] Deg360 = 35'd23592960;
   localparam logic signed [35:0] Deg180S = 36'sd11796480;
   localparam logic signed [35:0] Deg360S = 36'sd23592960;
   localparam logic signed [35:0] Deg90S = 36'sd5898240;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FOLD,
      ST_ROT,
      ST_PREP,
      ST_MUL,
      ST_FIN,
      ST_DONE
   } geo_state_type;

   // Arctangent of 2^-i in Q16.16 degrees, rounded to nearest.
   function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0: v = 32'sd2949120;
         5'd1: v = 32'sd1740967;
         5'd2: v = 32'sd919879;
         5'd3: v = 32'sd466945;
         5'd4: v = 32'sd234379;
         5'd5: v = 32'sd117304;
         5'd6: v = 32'sd58666;
         5'd7: v = 32'sd29335;
         5'd8: v = 32'sd14668;
         5'd9: v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/gyro_encoder_odometry.sv -----
// Odometry core: gyro heading, wheel step, CORDIC position update and speed.
//
// Usage: a sample word enters on the req_ channel (valid/stall) and one result
// word leaves on the rsp_ channel (valid/stall). The receiving side of each
// channel drives stall, and a word moves at a clock edge with valid high and
// stall low. The csr_ channel writes start_x, start_y and start_angle at
// indexes 0, 1 and 2; it is always ready and must only be used while idle.
// A normal sample passes from acceptance to the result word through heading
// reduction modulo 360 degrees (ST_MOD), one fold, one CORDIC iteration per
// cycle, a load of the multiplier, a bit-serial shift-add multiplier (sine
// and cosine products side by side), and a step each to saturate and
// register the result. The speed divider runs one quotient bit per cycle in
// parallel; the result waits in ST_DONE until it has finished. A restart
// sample loads the start position and goes straight to ST_DONE, from where it
// is placed in the output register once the slot is free. One sample is in
// work at a time, so req_stall is high from acceptance until the result is
// placed in the output register; the next sample is taken in the following
// cycle at the earliest. The output register holds its word while rsp_stall
// is high; a finished result then waits until the slot frees. Synchronous
// reset clears position, history, configuration and both channel controls.
module gyro_encoder_odometry #(
   parameter int CORDIC_ITERATIONS = geo_pkg::DefaultIterations
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_restart,
   input  logic [31:0] req_gyro_angle,
   input  logic [31:0] req_left_distance,
   input  logic [31:0] req_right_distance,
   input  logic [31:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_x_position,
   output logic [31:0] rsp_y_position,
   output logic [31:0] rsp_heading,
   output logic [31:0] rsp_speed,
   output logic        rsp_speed_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [geo_pkg::CntW-1:0] LastIter = geo_pkg::CntW'(CORDIC_ITERATIONS - 1);

   geo_pkg::geo_state_type state_ff, state_in;
   logic [geo_pkg::CntW-1:0] cnt_ff, cnt_in;

   logic [31:0] start_x_ff, start_y_ff, start_ang_ff;
   logic [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0] prev_mean_ff, prev_mean_in, prev_time_ff, prev_time_in;
   logic [31:0] heading_ff, heading_in;
   logic [34:0] red_ff, red_in;
   logic signed [31:0] z_ff, z_in;
   logic neg_cos_ff, neg_cos_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [32:0] step_mag_ff, step_mag_in;
   logic step_neg_ff, step_neg_in;
   logic [33:0] mx_hi_ff, mx_hi_in, my_hi_ff, my_hi_in;
   logic [31:0] mx_lo_ff, mx_lo_in, my_lo_ff, my_lo_in;
   logic px_neg_ff, px_neg_in, py_neg_ff, py_neg_in;

   logic div_busy_ff, div_busy_in;
   logic [geo_pkg::CntW-1:0] div_cnt_ff, div_cnt_in;
   logic [31:0] div_rem_ff, div_rem_in, dt_ff, dt_in;
   logic [48:0] div_q_ff, div_q_in;
   logic spd_ok_ff, spd_ok_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [31:0] rsp_head_ff, rsp_head_in, rsp_speed_ff, rsp_speed_in;
   logic rsp_sv_ff, rsp_sv_in;

   logic accept;
   assign accept = req_valid && (state_ff == geo_pkg::ST_IDLE);
   assign req_stall = (state_ff != geo_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_position = rsp_x_ff;
   assign rsp_y_position = rsp_y_ff;
   assign rsp_heading = rsp_head_ff;
   assign rsp_speed = rsp_speed_ff;
   assign rsp_speed_valid = rsp_sv_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         start_ang_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            geo_pkg::CsrStartX: start_x_ff <= csr_wdata;
            geo_pkg::CsrStartY: start_y_ff <= csr_wdata;
            geo_pkg::CsrStartAngle: start_ang_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Bit-serial restoring divider for the speed, one quotient bit a cycle.
   always_comb begin
      logic [32:0] trial;
      logic ge;
      trial = {div_rem_ff, div_q_ff[48]};
      ge = (trial >= {1'b0, dt_ff});
      div_busy_in = div_busy_ff;
      div_cnt_in = div_cnt_ff;
      div_rem_in = div_rem_ff;
      div_q_in = div_q_ff;
      if (div_busy_ff) begin
         div_rem_in = ge ? 32'(trial - {1'b0, dt_ff}) : trial[31:0];
         div_q_in = {div_q_ff[47:0], ge};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == geo_pkg::CntW'(geo_pkg::DivSteps - 1)) begin
            div_busy_in = 1'b0;
         end
      end
      if (accept) begin
         div_busy_in = 1'b0;
         div_cnt_in = '0;
         div_rem_in = '0;
         div_q_in = {step_mag_in, 16'd0};
         if (!req_restart && (dt_in != 32'd0)) begin
            div_busy_in = 1'b1;
         end
      end
   end

   // Sequencer and the serial datapath it steps.
   always_comb begin
      logic signed [32:0] hsum, dsum, step;
      logic signed [34:0] hs35;
      logic [34:0] sub;
      logic signed [35:0] r;
      logic signed [33:0] dx, dy, at, s_val, c_val;
      logic [33:0] s_mag, c_mag, sum_x, sum_y;
      logic signed [65:0] prod_x, prod_y;
      logic signed [35:0] dxp, dyp, npx, npy;
      logic [48:0] q;
      logic slot_free;

      hsum = {req_gyro_angle[31], req_gyro_angle} + {start_ang_ff[31], start_ang_ff};
      dsum = {req_left_distance[31], req_left_distance}
             + {req_right_distance[31], req_right_distance};
      step = {dsum[32], dsum[32:1]} - {prev_mean_ff[31], prev_mean_ff};
      hs35 = 35'(hsum);
      sub = geo_pkg::Deg360 << (4'd8 - cnt_ff[3:0]);
      r = 36'(signed'({1'b0, red_ff}));
      dx = cy_ff >>> cnt_ff[4:0];
      dy = cx_ff >>> cnt_ff[4:0];
      at = 34'(geo_pkg::atan_deg(cnt_ff[4:0]));
      s_val = cy_ff;
      c_val = neg_cos_ff ? -cx_ff : cx_ff;
      s_mag = s_val[33] ? 34'(-s_val) : 34'(s_val);
      c_mag = c_val[33] ? 34'(-c_val) : 34'(c_val);
      sum_x = mx_hi_ff + (mx_lo_ff[0] ? {1'b0, step_mag_ff} : 34'd0);
      sum_y = my_hi_ff + (my_lo_ff[0] ? {1'b0, step_mag_ff} : 34'd0);
      prod_x = signed'({1'b0, mx_hi_ff[32:0], mx_lo_ff});
      prod_y = signed'({1'b0, my_hi_ff[32:0], my_lo_ff});
      if (px_neg_ff) prod_x = -prod_x;
      if (py_neg_ff) prod_y = -prod_y;
      prod_x = prod_x + 66'sd536870912;
      prod_y = prod_y + 66'sd536870912;
      dxp = prod_x[65:30];
      dyp = prod_y[65:30];
      npx = 36'(signed'(pos_x_ff)) + dxp;
      npy = 36'(signed'(pos_y_ff)) + dyp;
      q = div_q_ff;
      slot_free = !rsp_valid_ff || !rsp_stall;

      state_in = state_ff;
      cnt_in = cnt_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      prev_mean_in = prev_mean_ff;
      prev_time_in = prev_time_ff;
      heading_in = heading_ff;
      red_in = red_ff;
      z_in = z_ff;
      neg_cos_in = neg_cos_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      step_neg_in = step_neg_ff;
      step_mag_in = step[32] ? 33'(-step) : 33'(step);
      dt_in = req_time_now - prev_time_ff;
      mx_hi_in = mx_hi_ff;
      mx_lo_in = mx_lo_ff;
      my_hi_in = my_hi_ff;
      my_lo_in = my_lo_ff;
      px_neg_in = px_neg_ff;
      py_neg_in = py_neg_ff;
      spd_ok_in = spd_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_head_in = rsp_head_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_sv_in = rsp_sv_ff;

      case (state_ff)
         geo_pkg::ST_IDLE: begin
            if (accept) begin
               // Heading output saturates; the trig path keeps the exact sum.
               if (hsum[32] != hsum[31]) begin
                  heading_in = hsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  heading_in = hsum[31:0];
               end
               red_in = hs35[34] ? 35'(hs35 + (geo_pkg::Deg360 << 8)) : 35'(hs35);
               step_neg_in = step[32];
               prev_mean_in = dsum[32:1];
               prev_time_in = req_time_now;
               spd_ok_in = !req_restart && (dt_in != 32'd0);
               cnt_in = '0;
               if (req_restart) begin
                  pos_x_in = start_x_ff;
                  pos_y_in = start_y_ff;
                  state_in = geo_pkg::ST_DONE;
               end else begin
                  state_in = geo_pkg::ST_MOD;
               end
            end
         end
         geo_pkg::ST_MOD: begin
            // Subtract 360 degrees scaled by 256 down to 1, one per cycle.
            if (red_ff >= sub) red_in = red_ff - sub;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == geo_pkg::CntW'(8)) begin
               cnt_in = '0;
               state_in = geo_pkg::ST_FOLD;
            end
         end
         geo_pkg::ST_FOLD: begin
            if (r >= geo_pkg::Deg180S) r = r - geo_pkg::Deg360S;
            neg_cos_in = 1'b0;
            if (r > geo_pkg::Deg90S) begin
               r = geo_pkg::Deg180S - r;
               neg_cos_in = 1'b1;
            end else if (r < -geo_pkg::Deg90S) begin
               r = -geo_pkg::Deg180S - r;
               neg_cos_in = 1'b1;
            end
            z_in = 32'(r);
            cx_in = geo_pkg::CordicGain;
            cy_in = '0;
            state_in = geo_pkg::ST_ROT;
         end
         geo_pkg::ST_ROT: begin
            if (!z_ff[31]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               z_in = z_ff - at[31:0];
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               z_in = z_ff + at[31:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastIter) begin
               cnt_in = '0;
               state_in = geo_pkg::ST_PREP;
            end
         end
         geo_pkg::ST_PREP: begin
            mx_hi_in = '0;
            my_hi_in = '0;
            mx_lo_in = s_mag[31:0];
            my_lo_in = c_mag[31:0];
            px_neg_in = step_neg_ff ^ s_val[33];
            py_neg_in = step_neg_ff ^ c_val[33];
            state_in = geo_pkg::ST_MUL;
         end
         geo_pkg::ST_MUL: begin
            mx_hi_in = {1'b0, sum_x[33:1]};
            mx_lo_in = {sum_x[0], mx_lo_ff[31:1]};
            my_hi_in = {1'b0, sum_y[33:1]};
            my_lo_in = {sum_y[0], my_lo_ff[31:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == geo_pkg::CntW'(31)) begin
               cnt_in = '0;
               state_in = geo_pkg::ST_FIN;
            end
         end
         geo_pkg::ST_FIN: begin
            if (npx[35:31] != {5{npx[31]}}) begin
               pos_x_in = npx[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               pos_x_in = npx[31:0];
            end
            if (npy[35:31] != {5{npy[31]}}) begin
               pos_y_in = npy[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               pos_y_in = npy[31:0];
            end
            state_in = geo_pkg::ST_DONE;
         end
         geo_pkg::ST_DONE: begin
            if (!div_busy_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = pos_x_ff;
               rsp_y_in = pos_y_ff;
               rsp_head_in = heading_ff;
               rsp_sv_in = spd_ok_ff;
               if (!spd_ok_ff) begin
                  rsp_speed_in = '0;
               end else if (step_neg_ff) begin
                  rsp_speed_in = (q > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-q);
               end else begin
                  rsp_speed_in = (q > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
               end
               state_in = geo_pkg::ST_IDLE;
            end
         end
         default: state_in = geo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= geo_pkg::ST_IDLE;
         cnt_ff <= '0;
         div_busy_ff <= 1'b0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         prev_mean_ff <= '0;
         prev_time_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         div_busy_ff <= div_busy_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         prev_mean_ff <= prev_mean_in;
         prev_time_ff <= prev_time_in;
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
      red_ff <= red_in;
      z_ff <= z_in;
      neg_cos_ff <= neg_cos_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      step_mag_ff <= accept ? step_mag_in : step_mag_ff;
      step_neg_ff <= step_neg_in;
      mx_hi_ff <= mx_hi_in;
      mx_lo_ff <= mx_lo_in;
      my_hi_ff <= my_hi_in;
      my_lo_ff <= my_lo_in;
      px_neg_ff <= px_neg_in;
      py_neg_ff <= py_neg_in;
      div_rem_ff <= div_rem_in;
      div_q_ff <= div_q_in;
      dt_ff <= accept ? dt_in : dt_ff;
      spd_ok_ff <= spd_ok_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_head_ff <= rsp_head_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_sv_ff <= rsp_sv_in;
   end

`include "gyro_encoder_odometry_assert.svh"

   // The divider only runs for a sample that is still being worked on.
   `GEO_ASSERT_SAME(a_div_in_work, clock, reset, div_busy_ff, state_ff != geo_pkg::ST_IDLE)
   // A released result always shows up on the output the next cycle.
   `GEO_ASSERT_NEXT(a_done_shows, clock, reset, (state_ff == geo_pkg::ST_DONE) && !div_busy_ff && (!rsp_valid_ff || !rsp_stall), rsp_valid && (state_ff == geo_pkg::ST_IDLE))
   // An invalid speed is always reported as zero.
   `GEO_ASSERT_SAME(a_speed_zero, clock, reset, rsp_valid && !rsp_speed_valid, rsp_speed == 32'd0)

endmodule
